// File: rtl/swgr_pkg.sv
package swgr_pkg;

   // configuration register widths and indexes
   localparam int unsigned LEN_W      = 30;
   localparam int unsigned MARGIN_W   = 16;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 30;

   localparam logic [CSR_ADDR_W-1:0] CSR_LENGTH_X        = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LENGTH_Y        = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BAND_THICKNESS  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_APPROACH_MARGIN = 2'd3;

   localparam logic [LEN_W-1:0]    LENGTH_X_RST        = 30'd458752;
   localparam logic [LEN_W-1:0]    LENGTH_Y_RST        = 30'd196608;
   localparam logic [LEN_W-1:0]    BAND_THICKNESS_RST  = 30'd52429;
   localparam logic [MARGIN_W-1:0] APPROACH_MARGIN_RST = 16'd66;

   // 1/sqrt(2) in Q16.16
   localparam logic signed [51:0] INV_SQRT2_Q16 = 52'sd46341;

   // wall kind codes
   localparam logic [2:0] KIND_RIGHT = 3'd0;
   localparam logic [2:0] KIND_LEFT  = 3'd1;
   localparam logic [2:0] KIND_NORTH = 3'd2;
   localparam logic [2:0] KIND_SOUTH = 3'd3;
   localparam logic [2:0] KIND_RN    = 3'd4;
   localparam logic [2:0] KIND_RS    = 3'd5;
   localparam logic [2:0] KIND_LN    = 3'd6;
   localparam logic [2:0] KIND_LS    = 3'd7;

   localparam logic signed [33:0] MAX32_W34 = 34'sd2147483647;
   localparam logic signed [33:0] MIN32_W34 = -34'sd2147483648;

   typedef struct packed {
      logic [LEN_W-1:0]    length_x;
      logic [LEN_W-1:0]    length_y;
      logic [LEN_W-1:0]    band_thickness;
      logic [MARGIN_W-1:0] approach_margin;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] press;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } item_type;

   typedef struct packed {
      logic signed [31:0] ghost_x;
      logic signed [31:0] ghost_y;
      logic signed [31:0] ghost_press;
      logic signed [31:0] ghost_vx;
      logic signed [31:0] ghost_vy;
      logic [2:0]         wall_kind;
      logic               last_ghost;
   } ghost_type;

   // clamp a 34-bit signed value into the 32-bit signed range
   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > MAX32_W34) begin
         r = 32'sh7FFFFFFF;
      end else if (v < MIN32_W34) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/swgr_ifs.sv
interface swgr_req_if import swgr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] press;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;

   modport source (output valid, pos_x, pos_y, press, vel_x, vel_y, input ready);
   modport sink   (input valid, pos_x, pos_y, press, vel_x, vel_y, output ready);
endinterface

interface swgr_rsp_if import swgr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [31:0] ghost_x;
   logic signed [31:0] ghost_y;
   logic signed [31:0] ghost_press;
   logic signed [31:0] ghost_vx;
   logic signed [31:0] ghost_vy;
   logic [2:0]         wall_kind;
   logic               last_ghost;

   modport source (output valid, ghost_x, ghost_y, ghost_press, ghost_vx, ghost_vy,
                   wall_kind, last_ghost, input ready);
   modport sink   (input valid, ghost_x, ghost_y, ghost_press, ghost_vx, ghost_vy,
                   wall_kind, last_ghost, output ready);
endinterface

// File: rtl/swgr_csr.sv
module swgr_csr import swgr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_addr)
            CSR_LENGTH_X:        cfg_in.length_x        = csr_wr_data[LEN_W-1:0];
            CSR_LENGTH_Y:        cfg_in.length_y        = csr_wr_data[LEN_W-1:0];
            CSR_BAND_THICKNESS:  cfg_in.band_thickness  = csr_wr_data[LEN_W-1:0];
            CSR_APPROACH_MARGIN: cfg_in.approach_margin = csr_wr_data[MARGIN_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.length_x        <= LENGTH_X_RST;
         cfg_ff.length_y        <= LENGTH_Y_RST;
         cfg_ff.band_thickness  <= BAND_THICKNESS_RST;
         cfg_ff.approach_margin <= APPROACH_MARGIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/swgr_calc.sv
module swgr_calc import swgr_pkg::*; (
   input  cfg_type         cfg,
   input  item_type        item,
   output ghost_type [2:0] ghost_list,
   output logic [1:0]      n_ghost
);

   logic signed [33:0] x, y, vx, vy, lx, ly, t, rb, nb, margin;
   logic signed [33:0] gx_wide, gy_wide, proj_x, proj_y, appr_x, appr_y, diag_s;
   logic signed [51:0] diag_prod, diag_sum, margin_wide;
   logic               interior, outside, right, left, north, south, corner;
   logic               zero_x, zero_y, zero_d;
   logic signed [31:0] gx, gy, neg_vx, neg_vy, dvx, dvy;
   logic [2:0]         diag_kind;
   ghost_type          wall_x, wall_y, diag;

   always_comb begin
      x      = 34'(item.pos_x);
      y      = 34'(item.pos_y);
      vx     = 34'(item.vel_x);
      vy     = 34'(item.vel_y);
      lx     = $signed({4'b0, cfg.length_x});
      ly     = $signed({4'b0, cfg.length_y});
      t      = $signed({4'b0, cfg.band_thickness});
      margin = $signed({18'b0, cfg.approach_margin});
      rb     = lx - t;
      nb     = ly - t;

      interior = (x < rb) && (x > t) && (y < nb) && (y > t);
      outside  = (x > lx) || (x < 34'sd0) || (y > ly) || (y < 34'sd0);
      right    = (x >= rb);
      left     = !right && (x <= t);
      north    = (y >= nb);
      south    = !north && (y <= t);
      corner   = (right || left) && (north || south);

      // mirrored positions
      gx_wide = right ? (lx + lx - x) : -x;
      gy_wide = north ? (ly + ly - y) : -y;
      gx      = sat34(gx_wide);
      gy      = sat34(gy_wide);
      neg_vx  = sat34(-vx);
      neg_vy  = sat34(-vy);

      // approach tests on the outward normal
      proj_x = right ? vx : -vx;
      proj_y = north ? vy : -vy;
      appr_x = proj_x + margin;
      appr_y = proj_y + margin;
      zero_x = (appr_x <= 34'sd0);
      zero_y = (appr_y <= 34'sd0);

      // diagonal: normal sign per corner, exact compare against the scaled margin
      if (right && north) begin
         diag_s    = vx + vy;
         diag_kind = KIND_RN;
      end else if (right && south) begin
         diag_s    = vx - vy;
         diag_kind = KIND_RS;
      end else if (left && north) begin
         diag_s    = vy - vx;
         diag_kind = KIND_LN;
      end else begin
         diag_s    = -vx - vy;
         diag_kind = KIND_LS;
      end
      margin_wide = $signed({20'b0, cfg.approach_margin, 16'b0});
      diag_prod   = 52'(diag_s) * INV_SQRT2_Q16;
      diag_sum    = diag_prod + margin_wide;
      zero_d      = (diag_sum <= 52'sd0);

      // swap with negate on rn/ls, plain swap on rs/ln
      if (right == north) begin
         dvx = neg_vy;
         dvy = neg_vx;
      end else begin
         dvx = item.vel_y;
         dvy = item.vel_x;
      end

      wall_x.ghost_x     = gx;
      wall_x.ghost_y     = item.pos_y;
      wall_x.ghost_press = item.press;
      wall_x.ghost_vx    = zero_x ? 32'sd0 : neg_vx;
      wall_x.ghost_vy    = zero_x ? 32'sd0 : item.vel_y;
      wall_x.wall_kind   = right ? KIND_RIGHT : KIND_LEFT;
      wall_x.last_ghost  = !corner;

      wall_y.ghost_x     = item.pos_x;
      wall_y.ghost_y     = gy;
      wall_y.ghost_press = item.press;
      wall_y.ghost_vx    = zero_y ? 32'sd0 : item.vel_x;
      wall_y.ghost_vy    = zero_y ? 32'sd0 : neg_vy;
      wall_y.wall_kind   = north ? KIND_NORTH : KIND_SOUTH;
      wall_y.last_ghost  = !corner;

      diag.ghost_x     = gx;
      diag.ghost_y     = gy;
      diag.ghost_press = item.press;
      diag.ghost_vx    = zero_d ? 32'sd0 : dvx;
      diag.ghost_vy    = zero_d ? 32'sd0 : dvy;
      diag.wall_kind   = diag_kind;
      diag.last_ghost  = 1'b1;

      if (corner) begin
         ghost_list[0] = wall_x;
         ghost_list[1] = wall_y;
         ghost_list[2] = diag;
      end else begin
         ghost_list[0] = (right || left) ? wall_x : wall_y;
         ghost_list[1] = wall_y;
         ghost_list[2] = diag;
      end

      if (interior || outside) begin
         n_ghost = 2'd0;
      end else if (corner) begin
         n_ghost = 2'd3;
      end else begin
         n_ghost = 2'd1;
      end
   end

endmodule

// File: rtl/solid_wall_ghost_particle_reflect.sv
// Ghost particle generator for a 2D box with solid walls (mirror scheme).
// req_bus (sink): one particle per beat - position, pressure, velocity, Q16.16.
// rsp_bus (source): ghost beats. A particle in an edge band gives one beat,
//   a corner particle gives three (x wall, y wall, diagonal), interior and
//   outside particles give none. last_ghost marks the final beat of a particle.
// csr_*: box length x/y, band thickness and approach margin; write only while
//   the block is idle. Index beyond the list is not decoded.
// Path: an accepted particle sits in the input register; each of its ghosts
//   is loaded into the result register, which drives rsp_bus.
// Throughput: one particle per cycle for edge, interior and outside particles
//   while rsp_bus does not stall; a corner particle holds the input register
//   until its ghosts are loaded one by one into the one shared result register.
// Reset (synchronous, active high): both registers empty, CSRs back to their
//   defaults (7.0 x 3.0 box, 0.8 band, margin 66).
// Stall: while rsp_bus.ready is low the result register holds; the input
//   register still takes a new particle once the current one has its last ghost
//   loaded or produces nothing, so one particle waits behind a stalled result.
module solid_wall_ghost_particle_reflect import swgr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   swgr_req_if.sink              req_bus,
   swgr_rsp_if.source            rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type         cfg;
   ghost_type [2:0] ghost_list;
   logic [1:0]      n_ghost;
   ghost_type       cur;

   // input register
   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   logic [1:0] idx_ff, idx_in;

   // result register
   ghost_type  out_ff, out_in;
   logic       out_valid_ff, out_valid_in;

   logic accept, out_load, item_done;

   swgr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   swgr_calc u_calc (
      .cfg        (cfg),
      .item       (item_ff),
      .ghost_list (ghost_list),
      .n_ghost    (n_ghost)
   );

   always_comb begin
      cur = ghost_list[idx_ff];

      // next ghost moves into the result register when that slot frees up
      out_load  = item_valid_ff && (n_ghost != 2'd0) && (!out_valid_ff || rsp_bus.ready);
      // particle retires on its last ghost, or at once if it makes none
      item_done = item_valid_ff && ((n_ghost == 2'd0) || (out_load && cur.last_ghost));

      req_bus.ready = !item_valid_ff || item_done;
      accept        = req_bus.valid && req_bus.ready;

      item_in.pos_x = req_bus.pos_x;
      item_in.pos_y = req_bus.pos_y;
      item_in.press = req_bus.press;
      item_in.vel_x = req_bus.vel_x;
      item_in.vel_y = req_bus.vel_y;

      if (accept) begin
         item_valid_in = 1'b1;
      end else if (item_done) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end

      if (accept) begin
         idx_in = 2'd0;
      end else if (out_load) begin
         idx_in = 2'(idx_ff + 2'd1);
      end else begin
         idx_in = idx_ff;
      end

      out_in = cur;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         idx_ff        <= 2'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         idx_ff        <= idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.ghost_x     = out_ff.ghost_x;
   assign rsp_bus.ghost_y     = out_ff.ghost_y;
   assign rsp_bus.ghost_press = out_ff.ghost_press;
   assign rsp_bus.ghost_vx    = out_ff.ghost_vx;
   assign rsp_bus.ghost_vy    = out_ff.ghost_vy;
   assign rsp_bus.wall_kind   = out_ff.wall_kind;
   assign rsp_bus.last_ghost  = out_ff.last_ghost;

endmodule

// File: verif/ghost_reflect_checker.sv
// Watches the particle and ghost channels, mirrors each accepted particle
// against its own copy of the box registers, and compares ghost beats in order.
module ghost_reflect_checker import swgr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   swgr_req_if                   req_mon,
   swgr_rsp_if                   rsp_mon,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int unsigned           mismatch_count,
   output int unsigned           ghosts_pending,
   output int unsigned           particles_seen,
   output int unsigned           ghosts_checked
);

   cfg_type   box;
   ghost_type pending_ghosts[$];

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // ghost velocity is zeroed when the particle moves off the wall
   function automatic bit wall_at_rest(longint proj);
      return proj + longint'(box.approach_margin) <= 0;
   endfunction

   // diagonal projection is s/sqrt2, kept exact by scaling both sides
   function automatic bit corner_at_rest(longint s);
      return s * longint'(INV_SQRT2_Q16) + longint'(box.approach_margin) * 65536 <= 0;
   endfunction

   function automatic ghost_type make_ghost(longint gx, longint gy, logic signed [31:0] press,
                                            bit at_rest, longint vx, longint vy,
                                            logic [2:0] kind, bit last);
      ghost_type g;
      g.ghost_x     = clamp32(gx);
      g.ghost_y     = clamp32(gy);
      g.ghost_press = press;
      g.ghost_vx    = at_rest ? 32'sd0 : clamp32(vx);
      g.ghost_vy    = at_rest ? 32'sd0 : clamp32(vy);
      g.wall_kind   = kind;
      g.last_ghost  = last;
      return g;
   endfunction

   // append one predicted ghost at the tail of the queue
   function automatic void queue_ghost(ghost_type g);
      pending_ghosts.insert(pending_ghosts.size(), g);
   endfunction

   task automatic mirror_particle(input item_type p);
      longint x, y, vx, vy, lx, ly, t, rb, nb, gx, gy;
      bit     right, left, north, south, corner;
      x  = $signed(p.pos_x);
      y  = $signed(p.pos_y);
      vx = $signed(p.vel_x);
      vy = $signed(p.vel_y);
      lx = longint'(box.length_x);
      ly = longint'(box.length_y);
      t  = longint'(box.band_thickness);
      rb = lx - t;
      nb = ly - t;
      if (x < rb && x > t && y < nb && y > t) begin
         return;
      end
      if (x > lx || x < 0 || y > ly || y < 0) begin
         return;
      end
      right  = (x >= rb);
      left   = !right && (x <= t);
      north  = (y >= nb);
      south  = !north && (y <= t);
      corner = (right || left) && (north || south);
      if (right) begin
         queue_ghost(make_ghost(2 * lx - x, y, p.press, wall_at_rest(vx),
                                -vx, vy, KIND_RIGHT, !corner));
      end else if (left) begin
         queue_ghost(make_ghost(-x, y, p.press, wall_at_rest(-vx),
                                -vx, vy, KIND_LEFT, !corner));
      end
      if (north) begin
         queue_ghost(make_ghost(x, 2 * ly - y, p.press, wall_at_rest(vy),
                                vx, -vy, KIND_NORTH, !corner));
      end else if (south) begin
         queue_ghost(make_ghost(x, -y, p.press, wall_at_rest(-vy),
                                vx, -vy, KIND_SOUTH, !corner));
      end
      if (corner) begin
         gx = right ? 2 * lx - x : -x;
         gy = north ? 2 * ly - y : -y;
         if (right && north) begin
            queue_ghost(make_ghost(gx, gy, p.press, corner_at_rest(vx + vy),
                                   -vy, -vx, KIND_RN, 1'b1));
         end else if (right) begin
            queue_ghost(make_ghost(gx, gy, p.press, corner_at_rest(vx - vy),
                                   vy, vx, KIND_RS, 1'b1));
         end else if (north) begin
            queue_ghost(make_ghost(gx, gy, p.press, corner_at_rest(vy - vx),
                                   vy, vx, KIND_LN, 1'b1));
         end else begin
            queue_ghost(make_ghost(gx, gy, p.press, corner_at_rest(-vx - vy),
                                   -vy, -vx, KIND_LS, 1'b1));
         end
      end
   endtask

   function automatic void check_field(string tag, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t  %s mismatch: expected %h, actual %h", $time, tag, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : watch
      ghost_type want;
      item_type  p;
      if (reset) begin
         box.length_x        = LENGTH_X_RST;
         box.length_y        = LENGTH_Y_RST;
         box.band_thickness  = BAND_THICKNESS_RST;
         box.approach_margin = APPROACH_MARGIN_RST;
         pending_ghosts.delete();
         mismatch_count = 0;
         particles_seen = 0;
         ghosts_checked = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_ghosts.size() == 0) begin
               $display("%0t  ghost beat with none expected: x %h y %h kind %0d",
                        $time, rsp_mon.ghost_x, rsp_mon.ghost_y, rsp_mon.wall_kind);
               mismatch_count++;
            end else begin
               want = pending_ghosts.pop_front();
               check_field("ghost_x", want.ghost_x, rsp_mon.ghost_x);
               check_field("ghost_y", want.ghost_y, rsp_mon.ghost_y);
               check_field("ghost_press", want.ghost_press, rsp_mon.ghost_press);
               check_field("ghost_vx", want.ghost_vx, rsp_mon.ghost_vx);
               check_field("ghost_vy", want.ghost_vy, rsp_mon.ghost_vy);
               check_field("wall_kind", 32'(want.wall_kind), 32'(rsp_mon.wall_kind));
               check_field("last_ghost", 32'(want.last_ghost), 32'(rsp_mon.last_ghost));
               ghosts_checked++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            p.pos_x = req_mon.pos_x;
            p.pos_y = req_mon.pos_y;
            p.press = req_mon.press;
            p.vel_x = req_mon.vel_x;
            p.vel_y = req_mon.vel_y;
            mirror_particle(p);
            particles_seen++;
         end
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_LENGTH_X:        box.length_x        = csr_wr_data[LEN_W-1:0];
               CSR_LENGTH_Y:        box.length_y        = csr_wr_data[LEN_W-1:0];
               CSR_BAND_THICKNESS:  box.band_thickness  = csr_wr_data[LEN_W-1:0];
               CSR_APPROACH_MARGIN: box.approach_margin = csr_wr_data[MARGIN_W-1:0];
               default: ;
            endcase
         end
      end
      ghosts_pending <= pending_ghosts.size();
   end

endmodule

// File: verif/tb_solid_wall_ghost_particle_reflect.sv
// Stimulus and verdict for the ghost particle generator. The checker beside
// the block does all prediction; this module only feeds particles, sets the
// box registers between phases and decides pass or fail.
module tb_solid_wall_ghost_particle_reflect;
   import swgr_pkg::*;

   localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no beat on either side
   localparam int unsigned SETTLE_LIMIT = 5000;
   localparam longint      Q_ONE        = 65536;
   localparam logic signed [31:0] S32_MIN = 32'sh80000000;
   localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   swgr_req_if req_bus ();
   swgr_rsp_if rsp_bus ();

   int unsigned mismatch_count;
   int unsigned ghosts_pending;
   int unsigned particles_seen;
   int unsigned ghosts_checked;
   int unsigned quiet_cycles;
   int unsigned box_settings;

   // stimulus-side copy of the box, used only to aim particles at the bands
   longint span_x, span_y, band, margin;
   int unsigned req_gap_odds;   // 0..8, chance in eighths of a gap before a beat
   bit          calm_tail;      // final stretch: no idling on either side

   solid_wall_ghost_particle_reflect i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   ghost_reflect_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_addr       (csr_addr),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .ghosts_pending (ghosts_pending),
      .particles_seen (particles_seen),
      .ghosts_checked (ghosts_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake shows up as a long run of cycles where
   // neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t  no beat for %0d cycles", $time, quiet_cycles);
         $display("solid_wall_ghost_particle_reflect regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Ghost-side backpressure: bursts of stalled cycles of random length, with calm
   // windows of full throughput in between, none at all in the tail.
   initial begin
      int unsigned hold;
      int unsigned calm_left;
      hold = 0;
      calm_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold != 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (calm_tail || calm_left != 0) begin
            if (calm_left != 0) begin
               calm_left--;
            end
            rsp_bus.ready <= 1'b1;
         end else begin
            case ($urandom_range(0, 15))
               0, 1: begin
                  hold = $urandom_range(0, 11);
                  rsp_bus.ready <= 1'b0;
               end
               2: begin
                  calm_left = $urandom_range(30, 120);
                  rsp_bus.ready <= 1'b1;
               end
               default: rsp_bus.ready <= 1'b1;
            endcase
         end
      end
   end

   // One register write per cycle; the enable stays high across the four
   // writes and drops once at the end.
   task automatic set_box(input longint lx, input longint ly, input longint t, input longint m);
      csr_wr_en   <= 1'b1;
      csr_addr    <= CSR_LENGTH_X;
      csr_wr_data <= CSR_DATA_W'(lx);
      @(posedge clock);
      csr_addr    <= CSR_LENGTH_Y;
      csr_wr_data <= CSR_DATA_W'(ly);
      @(posedge clock);
      csr_addr    <= CSR_BAND_THICKNESS;
      csr_wr_data <= CSR_DATA_W'(t);
      @(posedge clock);
      csr_addr    <= CSR_APPROACH_MARGIN;
      csr_wr_data <= CSR_DATA_W'(m);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
      span_x = lx;
      span_y = ly;
      band   = t;
      margin = m;
      box_settings++;
   endtask

   // Valid stays high between back-to-back beats; it only drops for a gap.
   task automatic send_particle(input logic signed [31:0] px, input logic signed [31:0] py,
                                input logic signed [31:0] pr, input logic signed [31:0] vx,
                                input logic signed [31:0] vy);
      if (!calm_tail && $urandom_range(1, 8) <= req_gap_odds) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pos_x <= px;
      req_bus.pos_y <= py;
      req_bus.press <= pr;
      req_bus.vel_x <= vx;
      req_bus.vel_y <= vy;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // Drop valid and wait for the last ghost, then let a silent particle
   // still sitting in the input register retire.
   task automatic settle();
      int unsigned waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (ghosts_pending != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (ghosts_pending != 0) begin
         $display("%0t  %0d ghosts never arrived", $time, ghosts_pending);
         $display("solid_wall_ghost_particle_reflect regression: fail");
         $finish;
      end
      repeat (4) @(posedge clock);
   endtask

   // Mostly in or on the edge of a band, some interior, some just outside,
   // some fully random words.
   function automatic logic signed [31:0] pick_coord(longint span, longint t);
      longint v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = $urandom_range(0, 32'(t));
         3, 4, 5: v = span - longint'($urandom_range(0, 32'(t)));
         6:       v = $urandom_range(0, 32'(span));
         7: begin
            case ($urandom_range(0, 5))
               0:       v = 0;
               1:       v = t;
               2:       v = span;
               3:       v = span - t;
               4:       v = t + 1;
               default: v = span - t - 1;
            endcase
         end
         8: begin
            if ($urandom_range(0, 1) == 1) begin
               v = span + longint'($urandom_range(1, 70000));
            end else begin
               v = -longint'($urandom_range(1, 70000));
            end
         end
         default: v = longint'(int'($urandom()));
      endcase
      return v[31:0];
   endfunction

   // Velocities cluster around the wall and diagonal rest thresholds.
   function automatic logic signed [31:0] pick_vel();
      longint v;
      case ($urandom_range(0, 7))
         0, 1: v = longint'(int'($urandom()));
         2, 3: v = longint'($urandom_range(0, 262144)) - 131072;
         4:    v = -margin + longint'($urandom_range(0, 4)) - 2;
         5:    v = -((margin * 65536) / 46341) + longint'($urandom_range(0, 4)) - 2;
         6: begin
            case ($urandom_range(0, 3))
               0:       v = longint'(S32_MIN);
               1:       v = longint'(S32_MAX);
               2:       v = 0;
               default: v = -1;
            endcase
         end
         default: v = longint'($urandom_range(0, 4));
      endcase
      return v[31:0];
   endfunction

   task automatic send_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         send_particle(pick_coord(span_x, band), pick_coord(span_y, band),
                       int'($urandom()), pick_vel(), pick_vel());
      end
   endtask

   initial begin
      longint rb, nb;
      reset         <= 1'b1;
      csr_wr_en     <= 1'b0;
      csr_addr      <= CSR_LENGTH_X;
      csr_wr_data   <= '0;
      req_bus.valid <= 1'b0;
      req_bus.pos_x <= '0;
      req_bus.pos_y <= '0;
      req_bus.press <= '0;
      req_bus.vel_x <= '0;
      req_bus.vel_y <= '0;
      calm_tail     = 1'b0;
      req_gap_odds  = 2;
      box_settings  = 1;
      span_x        = LENGTH_X_RST;
      span_y        = LENGTH_Y_RST;
      band          = BAND_THICKNESS_RST;
      margin        = APPROACH_MARGIN_RST;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats on the reset box: 7.0 x 3.0, band 0.8, margin 66.
      rb = span_x - band;
      nb = span_y - band;
      // interior, then one step outside each wall
      send_particle(32'(span_x / 2), 32'(span_y / 2), 32'sd1, 32'(Q_ONE), 32'(Q_ONE));
      send_particle(-32'sd1, 32'(span_y / 2), 32'sd2, 32'(Q_ONE), 32'sd0);
      send_particle(32'(span_x + 1), 32'(span_y / 2), 32'sd3, 32'(Q_ONE), 32'sd0);
      send_particle(32'(span_x / 2), -32'sd1, 32'sd4, 32'sd0, 32'(Q_ONE));
      send_particle(32'(span_x / 2), 32'(span_y + 1), 32'sd5, 32'sd0, 32'(Q_ONE));
      // right wall: on the wall itself, on the inner band edge
      send_particle(32'(span_x), 32'(span_y / 2), S32_MAX, 32'(Q_ONE), 32'sd7);
      send_particle(32'(rb), 32'(span_y / 2), S32_MIN, -32'(Q_ONE), 32'sd7);
      // left wall: most negative velocity reflects into saturation
      send_particle(32'sd0, 32'(span_y / 2), 32'sd0, S32_MIN, 32'sd9);
      // left band edge right at the margin: rest, then one step over
      send_particle(32'(band), 32'(span_y / 2), -32'sd1, 32'(margin), 32'sd0);
      send_particle(32'(band), 32'(span_y / 2), -32'sd1, 32'(margin - 1), 32'sd0);
      send_particle(32'sd430000, 32'(span_y / 2), 32'sd11, S32_MIN, S32_MAX);
      // north and south walls
      send_particle(32'(span_x / 2), 32'(span_y), 32'sd12, 32'sd3, S32_MAX);
      send_particle(32'(span_x / 2), 32'(nb), 32'sd13, 32'sd3, 32'(-margin - 1));
      send_particle(32'(span_x / 2), 32'sd0, 32'sd14, 32'sd3, S32_MIN);
      send_particle(32'(span_x / 2), 32'(band), 32'sd15, 32'sd3, 32'(Q_ONE));
      // the four corners
      send_particle(32'(span_x), 32'(span_y), 32'sd16, 32'(Q_ONE), 32'(Q_ONE));
      send_particle(32'sd430000, 32'sd10000, 32'sd17, 32'(Q_ONE), -32'(Q_ONE));
      send_particle(32'sd10000, 32'sd180000, 32'sd18, -32'(Q_ONE), 32'(Q_ONE));
      send_particle(32'sd0, 32'sd0, 32'sd19, -32'(Q_ONE), -32'(Q_ONE));
      // diagonal rest threshold at margin 66: s = -93 reflects, s = -94 rests
      send_particle(32'sd0, 32'sd0, 32'sd20, 32'sd93, 32'sd0);
      send_particle(32'sd0, 32'sd0, 32'sd21, 32'sd94, 32'sd0);
      // corner velocity extremes, including saturating diagonal negation
      send_particle(32'(span_x), 32'(span_y), 32'sd22, S32_MIN, S32_MIN);
      send_particle(32'sd430000, 32'sd10000, 32'sd23, S32_MAX, S32_MIN);
      send_particle(32'sd10000, 32'sd180000, 32'sd24, S32_MIN, S32_MAX);
      send_particle(32'(span_x), 32'(span_y), 32'sd25, S32_MAX, S32_MIN);
      settle();

      // Random on the reset box, frequent sender gaps.
      req_gap_odds = 3;
      send_random(45);
      settle();

      // Random moderate box, sender never idles here.
      set_box($urandom_range(2 * 65536, 40 * 65536), $urandom_range(2 * 65536, 40 * 65536),
              $urandom_range(8192, 3 * 65536), $urandom_range(0, 65535));
      req_gap_odds = 0;
      send_random(45);
      settle();

      // Widest box, half-width band, largest margin.
      set_box(1073741823, 1073741823, 536870912, 65535);
      req_gap_odds = 5;
      send_random(30);
      settle();

      // Band wider than the box: inner band edges go negative.
      set_box(3 * Q_ONE, 2 * Q_ONE, 5 * Q_ONE, 0);
      req_gap_odds = 2;
      send_random(30);
      settle();

      // Zero-size box: only the origin is inside.
      set_box(0, 0, 0, 1);
      send_random(20);
      settle();

      // Last random box; the tail runs with no idling on either side.
      set_box($urandom_range(65536, 20 * 65536), $urandom_range(65536, 20 * 65536),
              $urandom_range(0, 2 * 65536), $urandom_range(0, 65535));
      req_gap_odds = 3;
      send_random(15);
      calm_tail = 1'b1;
      send_random(35);
      settle();

      $display("covered %0d particles over %0d box settings: reset box, random, widest, %s",
               particles_seen, box_settings, "band wider than box, zero size");
      $display("%0d ghost beats compared field by field, %0d field mismatches",
               ghosts_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("solid_wall_ghost_particle_reflect regression: pass");
      end else begin
         $display("solid_wall_ghost_particle_reflect regression: fail");
      end
      $finish;
   end

endmodule
